### rtl/assert_macros.svh
// assertion macros for the rtl folder
// assertions are compiled only in simulation; synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge, switched off while reset is low
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

### rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// types and constants of the page frame free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int NUM_FRAMES      = 4096;
  localparam int PAGE_SHIFT_BITS = 12;

  localparam int FUNC_W   = 2;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int RANGE_W  = FRAME_W + 1;
  localparam int LINK_W   = FRAME_W + 1;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RANGE = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_BAD_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_RANGE  = 2'd2,
    S_ACCESS = 2'd3
  } state_t;

endpackage

`default_nettype wire

### rtl/page_frame_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator
// lifo free list of page frames with a saturating reference count per frame
// ----------------------------------------------------------------------------
// Usage
//   A command beat is taken on a rising edge with start high and busy low.
//   in_func selects release range, allocate or free; the other in_ ports
//   carry its operands. Every command gives exactly one result beat:
//   out_valid is high for one cycle with out_status, out_alloc_index and
//   out_alloc_address. The receiver cannot stall; results are never held.
//   Steps, from the accepting edge to the result:
//     rejected or empty commands, allocate on an empty list: result registered for the next cycle
//     allocate and free: link and count memory read, then write in S_ACCESS
//     release range of N frames: one frame pushed per cycle in S_RANGE, then the result
//   busy drops in the cycle the result is shown, so a new command can be
//   taken there; no new command is taken while one is still in work.
//   After reset all NUM_FRAMES (4096) entries of the count memory are
//   swept to zero, one entry per cycle; busy stays high for that whole pass.
//   The link memory is not cleared: an entry is read only after a push.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module page_frame_free_list_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pfa_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [pfa_pkg::RANGE_W-1:0]   in_range_begin,
  input  wire logic [pfa_pkg::RANGE_W-1:0]   in_range_limit,
  input  wire logic [pfa_pkg::FRAME_W-1:0]   in_frame_index,
  output logic                               out_valid,
  output logic [pfa_pkg::STATUS_W-1:0]       out_status,
  output logic [pfa_pkg::FRAME_W-1:0]        out_alloc_index,
  output logic [pfa_pkg::ADDR_W-1:0]         out_alloc_address
);
  import pfa_pkg::*;

  // memories
  logic [LINK_W-1:0]  link_mem [NUM_FRAMES];
  logic [COUNT_W-1:0] cnt_mem  [NUM_FRAMES];
  logic [LINK_W-1:0]  link_rd_r;
  logic [COUNT_W-1:0] cnt_rd_r;

  // control and list state
  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [FRAME_W-1:0] head_r, head_nxt;
  logic               empty_r, empty_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [RANGE_W-1:0] lim_r, lim_nxt;
  func_t              func_r, func_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]  out_index_r, out_index_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  // memory ports
  logic [FRAME_W-1:0] rd_addr;
  logic               link_we;
  logic [FRAME_W-1:0] link_waddr;
  logic [LINK_W-1:0]  link_wdata;
  logic               cnt_we;
  logic [FRAME_W-1:0] cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;

  logic               accept;
  func_t              in_func_e;
  logic               range_bad;
  logic               range_none;
  logic               frame_bad;
  logic               range_last;
  logic [LINK_W-1:0]  push_link;

  assign accept     = start && (state_r == S_IDLE);
  assign in_func_e  = func_t'(in_func);
  assign range_bad  = (in_range_limit > RANGE_W'(NUM_FRAMES)) ||
                      (in_range_limit < in_range_begin);
  assign range_none = (in_range_limit == in_range_begin);
  assign frame_bad  = {1'b0, in_frame_index} >= RANGE_W'(NUM_FRAMES);
  assign range_last = (({1'b0, cur_r} + RANGE_W'(1)) == lim_r);
  // link written by a push: bottom mark when the list was empty
  assign push_link  = empty_r ? {1'b1, {FRAME_W{1'b0}}} : {1'b0, head_r};

  // reads are issued on the accepting edge, data used in the access cycle
  assign rd_addr = (in_func_e == FUNC_ALLOC) ? head_r : in_frame_index;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == FRAME_W'(NUM_FRAMES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (in_func_e)
            FUNC_RANGE: begin
              if (!range_bad && !range_none) state_nxt = S_RANGE;
            end
            FUNC_ALLOC: begin
              if (!empty_r) state_nxt = S_ACCESS;
            end
            FUNC_FREE: begin
              if (!frame_bad) state_nxt = S_ACCESS;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RANGE: begin
        if (range_last) state_nxt = S_IDLE;
      end
      S_ACCESS: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    empty_nxt      = empty_r;
    cur_nxt        = cur_r;
    lim_nxt        = lim_r;
    func_nxt       = func_r;
    frame_nxt      = frame_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_index_nxt  = '0;
    out_addr_nxt   = '0;
    link_we        = 1'b0;
    link_waddr     = cur_r;
    link_wdata     = push_link;
    cnt_we         = 1'b0;
    cnt_waddr      = clr_cnt_r;
    cnt_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        cnt_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + FRAME_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_func_e;
          frame_nxt = in_frame_index;
          cur_nxt   = in_range_begin[FRAME_W-1:0];
          lim_nxt   = in_range_limit;
          case (in_func_e)
            FUNC_RANGE: begin
              if (range_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BAD_RANGE;
              end else if (range_none) begin
                out_valid_nxt  = 1'b1;
              end
            end
            FUNC_ALLOC: begin
              if (empty_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end
            end
            FUNC_FREE: begin
              if (frame_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BAD_RANGE;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_RANGE: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        head_nxt   = cur_r;
        empty_nxt  = 1'b0;
        cur_nxt    = cur_r + FRAME_W'(1);
        if (range_last) out_valid_nxt = 1'b1;
      end
      S_ACCESS: begin
        out_valid_nxt = 1'b1;
        if (func_r == FUNC_ALLOC) begin
          // pop the head, the bottom mark empties the list
          if (link_rd_r[FRAME_W]) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
          end else begin
            head_nxt  = link_rd_r[FRAME_W-1:0];
          end
          cnt_we         = 1'b1;
          cnt_waddr      = head_r;
          cnt_wdata      = (cnt_rd_r == COUNT_MAX) ? cnt_rd_r : cnt_rd_r + COUNT_W'(1);
          out_index_nxt  = head_r;
          out_addr_nxt   = ADDR_W'(ADDR_W'(head_r) << PAGE_SHIFT_BITS);
        end else begin
          if (cnt_rd_r == '0) begin
            out_status_nxt = ST_DOUBLE_FREE;
          end else begin
            cnt_we    = 1'b1;
            cnt_waddr = frame_r;
            cnt_wdata = cnt_rd_r - COUNT_W'(1);
            // last reference gone: frame goes back on top
            if (cnt_rd_r == COUNT_W'(1)) begin
              link_we    = 1'b1;
              link_waddr = frame_r;
              head_nxt   = frame_r;
              empty_nxt  = 1'b0;
            end
          end
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    lim_r        <= lim_nxt;
    func_r       <= func_nxt;
    frame_r      <= frame_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_index   = out_index_r;
  assign out_alloc_address = out_addr_r;

  // every accepted command either starts work or reports at once
  `ASSERT_CLKRST(a_accept_progress, clk, rst_n, start && !busy |=> busy || out_valid, "accepted command neither busy nor reported")
  // memory access phase is followed directly by idle and always reports
  `ASSERT_CLKRST(a_access_reports, clk, rst_n, state_r == S_ACCESS |=> state_r == S_IDLE && out_valid, "access cycle did not report")
  // a failed or non-allocating result carries no frame
  `ASSERT_CLKRST(a_fail_no_frame, clk, rst_n, out_valid && out_status != ST_OK |-> out_alloc_index == '0 && out_alloc_address == '0, "failed result carries a frame")
  // every range push leaves the list non-empty
  `ASSERT_CLKRST(a_range_fills, clk, rst_n, state_r == S_RANGE |=> !empty_r, "range push left list empty")
  // no result while the count memory is being cleared
  `ASSERT_CLKRST(a_clear_silent, clk, rst_n, state_r == S_CLEAR |=> !out_valid, "result during clearing pass")

endmodule

`default_nettype wire
